// ===== rtl/core/lfm_pkg.sv =====
`timescale 1ns / 1ps

package lfm_pkg;

  // Display geometry
  localparam int PANEL_COUNT       = 3;
  localparam int PANEL_COLS        = 24;
  localparam int PANEL_ROWS        = 6;
  localparam int ENTRIES_PER_BOARD = 192;

  localparam int TOTAL_WIDTH = PANEL_COUNT * PANEL_COLS;
  localparam int STORE_DEPTH = PANEL_COUNT * ENTRIES_PER_BOARD;

  // Driver index space: 16 columns per row, upper half of a board folds to rows 6+
  localparam int DRV_COLS    = 16;
  localparam int COL_SPLIT   = 12;
  localparam int ROW_FOLD    = 6;
  localparam int CS_GAP_FROM = 6;
  localparam int CS_GAP      = 2;

  // Dim: v > DIM_KNEE becomes floor(v*17/20) = (v * DIM_MUL) >> DIM_SHIFT for 8-bit v
  localparam int DIM_KNEE  = 35;
  localparam int DIM_MUL   = 17 * 3277;
  localparam int DIM_SHIFT = 16;

  // Field widths
  localparam int OP_W = 3;
  localparam int X_W  = 7;
  localparam int Y_W  = 3;
  localparam int V_W  = 8;

  // Derived widths
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int SX_W   = $clog2(TOTAL_WIDTH);
  localparam int COL_W  = $clog2(PANEL_COLS);
  localparam int BRD_W  = (PANEL_COUNT > 1) ? $clog2(PANEL_COUNT) : 1;
  localparam int CS_W   = $clog2(DRV_COLS);
  localparam int SW_W   = 4;
  localparam int IDX_W  = SW_W + CS_W;
  localparam int MUL_W  = V_W + 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIM   = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic              accept;
    logic              zero_param;
    logic              pix_wr;
    logic              pix_rd;
    logic              sweep_wr;
    logic              dim_rd;
    logic              res_load;
    logic [ADDR_W-1:0] addr;
  } lfm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic res_free;
  } lfm_stat_t;

endpackage

// ===== rtl/core/lfm_cmd_if.sv =====
`timescale 1ns / 1ps

interface lfm_cmd_if
  import lfm_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [X_W-1:0]  x;
  logic [Y_W-1:0]  y;
  logic [V_W-1:0]  value;

  modport source (output valid, operation, x, y, value, input ready);
  modport sink   (input valid, operation, x, y, value, output ready);
endinterface

// ===== rtl/core/lfm_res_if.sv =====
`timescale 1ns / 1ps

interface lfm_res_if
  import lfm_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [V_W-1:0] read_value;
  logic           position_valid;

  modport source (output valid, read_value, position_valid, input ready);
  modport sink   (input valid, read_value, position_valid, output ready);
endinterface

// ===== rtl/core/lfm_ctrl.sv =====
`timescale 1ns / 1ps

module lfm_ctrl
  import lfm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  logic [OP_W-1:0] operation,
  output logic            cmd_ready,
  input  lfm_stat_t       stat,
  output lfm_cmd_t        ctl
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_DIM  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(STORE_DEPTH);

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd_ready  = 1'b0;
    ctl        = '0;
    ctl.addr   = cnt[ADDR_W-1:0];
    case (state)
      S_INIT: begin
        ctl.sweep_wr = 1'b1;
        if (cnt == CNT_LAST) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        cnt_next  = '0;
        if (cmd_valid) begin
          ctl.accept = 1'b1;
          case (operation)
            OP_WRITE: begin
              ctl.pix_wr = 1'b1;
              state_next = S_DONE;
            end
            OP_READ: begin
              ctl.pix_rd = 1'b1;
              state_next = S_DONE;
            end
            OP_CLEAR: begin
              ctl.zero_param = 1'b1;
              state_next     = S_FILL;
            end
            OP_FILL: state_next = S_FILL;
            OP_DIM:  state_next = S_DIM;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        ctl.sweep_wr = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIM: begin
        // read entry cnt; datapath writes back entry cnt-1 in the same cycle
        if (cnt == CNT_END) begin
          state_next = S_DONE;
        end else begin
          ctl.dim_rd = 1'b1;
          cnt_next   = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (stat.res_free) begin
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== rtl/core/lfm_dpath.sv =====
`timescale 1ns / 1ps

module lfm_dpath
  import lfm_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic [X_W-1:0] x,
  input  logic [Y_W-1:0] y,
  input  logic [V_W-1:0] value,
  input  lfm_cmd_t       ctl,
  output lfm_stat_t      stat,
  lfm_res_if.source      res
);

  logic [V_W-1:0]    mem [STORE_DEPTH];
  logic [V_W-1:0]    mem_q;

  logic [V_W-1:0]    param_q;
  logic              res_ok_q;
  logic              res_rd_q;
  logic              dim_pend_q;
  logic [ADDR_W-1:0] dim_addr_q;

  logic              in_bounds;
  logic              slot_ok;
  logic [SX_W-1:0]   sx;
  logic [Y_W-1:0]    sy;
  logic [BRD_W-1:0]  board;
  logic [COL_W-1:0]  col;
  logic              col_hi;
  logic [CS_W-1:0]   cs_base;
  logic [CS_W-1:0]   cs;
  logic [SW_W-1:0]   sw;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] slot;

  logic [MUL_W-1:0]  dim_prod;
  logic [V_W-1:0]    dim_scaled;
  logic [V_W-1:0]    dim_res;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [V_W-1:0]    wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // Position check, flip and board/column split
  always_comb begin
    in_bounds = (int'(x) < TOTAL_WIDTH) && (int'(y) < PANEL_ROWS);
    sx        = SX_W'(TOTAL_WIDTH - 1 - int'(x));
    sy        = Y_W'(PANEL_ROWS - 1 - int'(y));
    board     = '0;
    col       = COL_W'(sx);
    for (int b = 1; b < PANEL_COUNT; b++) begin
      if (int'(sx) >= b * PANEL_COLS) begin
        board = BRD_W'(b);
        col   = COL_W'(int'(sx) - b * PANEL_COLS);
      end
    end
  end

  // Remap into the driver index space
  always_comb begin
    col_hi  = int'(col) >= COL_SPLIT;
    cs_base = col_hi ? CS_W'(int'(col) - COL_SPLIT) : CS_W'(col);
    cs      = (int'(cs_base) >= CS_GAP_FROM) ? cs_base + CS_W'(CS_GAP) : cs_base;
    sw      = SW_W'(sy) + (col_hi ? SW_W'(ROW_FOLD) : '0);
    idx     = {sw, cs};
    slot_ok = in_bounds && (int'(idx) < ENTRIES_PER_BOARD) && (int'(board) < PANEL_COUNT);
    slot    = ADDR_W'(int'(board) * ENTRIES_PER_BOARD + int'(idx));
  end

  // Dim of the entry just read
  always_comb begin
    dim_prod   = MUL_W'(mem_q) * MUL_W'(DIM_MUL);
    dim_scaled = (int'(mem_q) > DIM_KNEE) ? dim_prod[DIM_SHIFT +: V_W] : mem_q;
    dim_res    = (param_q > dim_scaled) ? '0 : dim_scaled - param_q;
  end

  // Store port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ctl.addr;
    wr_data = param_q;
    if (ctl.pix_wr && slot_ok) begin
      wr_en   = 1'b1;
      wr_addr = slot;
      wr_data = value;
    end else if (ctl.sweep_wr) begin
      wr_en = 1'b1;
    end else if (dim_pend_q) begin
      wr_en   = 1'b1;
      wr_addr = dim_addr_q;
      wr_data = dim_res;
    end
    rd_en   = (ctl.pix_rd && slot_ok) || ctl.dim_rd;
    rd_addr = ctl.dim_rd ? ctl.addr : slot;
  end

  // Pixel store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Per-transaction operand and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      param_q    <= '0;
      dim_pend_q <= 1'b0;
    end else begin
      dim_pend_q <= ctl.dim_rd;
      if (ctl.accept) begin
        param_q <= ctl.zero_param ? '0 : value;
      end
    end
  end

  always_ff @(posedge clk) begin
    dim_addr_q <= ctl.addr;
    if (ctl.accept) begin
      res_ok_q <= (ctl.pix_wr || ctl.pix_rd) && in_bounds;
      res_rd_q <= ctl.pix_rd && slot_ok;
    end
  end

  // Output register
  assign stat.res_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctl.res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res.read_value     <= res_rd_q ? mem_q : '0;
      res.position_valid <= res_ok_q;
    end
  end

endmodule

// ===== rtl/core/led_matrix_framebuffer_mapper.sv =====
`timescale 1ns / 1ps

// Brightness framebuffer for a row of LED matrix boards (576 entries of 8 bits).
// Each command transaction yields exactly one result transaction. A pixel write,
// a pixel read or an unused operation code is accepted in the idle state; its
// result is loaded in the done state, once the output register is free. Clear
// and fill sweep the store through its single write port, one entry a cycle;
// dim reads one entry and writes back the previous one each cycle. After reset
// a clearing pass over every entry runs before the first command is accepted.
// A new command may be accepted while the previous result still waits in the
// output register.

module led_matrix_framebuffer_mapper
  import lfm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  lfm_cmd_if.sink   cmd,
  lfm_res_if.source res
);

  lfm_cmd_t  ctl;
  lfm_stat_t stat;
  logic      ready;

  assign cmd.ready = ready;

  lfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .operation (cmd.operation),
    .cmd_ready (ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  lfm_dpath u_dpath (
    .clk   (clk),
    .rst   (rst),
    .x     (cmd.x),
    .y     (cmd.y),
    .value (cmd.value),
    .ctl   (ctl),
    .stat  (stat),
    .res   (res)
  );

`ifndef SYNTH
  // A non-zero read-back only comes from an in-range pixel read
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.read_value != '0) |-> res.position_valid)
    else $error("non-zero read value without a valid position");

  // Accepting a command moves the block out of the idle state, the only state that raises ready
  assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command accepted on consecutive cycles");

  // A result is only loaded when the output register can take it
  assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |-> (!res.valid || res.ready))
    else $error("result loaded over a pending result");

  // Sweeps never collide with a pixel transaction
  assert property (@(posedge clk) disable iff (rst)
    (ctl.sweep_wr || ctl.dim_rd) |-> !(ctl.pix_wr || ctl.pix_rd || cmd.ready))
    else $error("sweep overlaps a pixel command");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lfm_pkg::*;

  // Codes with no operation behind them
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  localparam int RANDOM_ITEMS = 750;
  localparam int PHASE_COUNT  = 4;
  localparam int LONG_HOLD    = 80;

  typedef struct packed {
    logic [V_W-1:0] read_value;
    logic           position_valid;
  } pixel_result_t;

  // Shadow framebuffer and the queue of responses it predicts
  class framebuffer_scoreboard;
    logic [V_W-1:0] shadow_store [STORE_DEPTH];
    pixel_result_t  pending_results [$];
    int unsigned    mismatches;

    function new();
      foreach (shadow_store[i]) shadow_store[i] = '0;
      mismatches = 0;
    endfunction

    // Flip, split per board and fold into the 16-wide driver index space
    function bit map_pixel(input int px, input int py, output int slot);
      int sx, sy, board, col, sw, cs, idx;
      slot = 0;
      if (px >= TOTAL_WIDTH || py >= PANEL_ROWS) return 1'b0;
      sx    = TOTAL_WIDTH - 1 - px;
      sy    = PANEL_ROWS - 1 - py;
      board = sx / PANEL_COLS;
      col   = sx % PANEL_COLS;
      sw    = (col < COL_SPLIT) ? sy : sy + ROW_FOLD;
      cs    = col % COL_SPLIT;
      if (cs >= CS_GAP_FROM) cs = cs + CS_GAP;
      idx = sw * DRV_COLS + cs;
      if (idx >= ENTRIES_PER_BOARD || board >= PANEL_COUNT) return 1'b0;
      slot = board * ENTRIES_PER_BOARD + idx;
      return 1'b1;
    endfunction

    function void note_command(input logic [OP_W-1:0] op, input logic [X_W-1:0] px,
                               input logic [Y_W-1:0] py, input logic [V_W-1:0] val);
      pixel_result_t want;
      int slot, level;
      want = '0;
      case (op)
        OP_WRITE, OP_READ: begin
          want.position_valid = (px < TOTAL_WIDTH) && (py < PANEL_ROWS);
          if (map_pixel(int'(px), int'(py), slot)) begin
            if (op == OP_WRITE) shadow_store[slot] = val;
            else want.read_value = shadow_store[slot];
          end
        end
        OP_CLEAR: begin
          foreach (shadow_store[i]) shadow_store[i] = '0;
        end
        OP_FILL: begin
          foreach (shadow_store[i]) shadow_store[i] = val;
        end
        OP_DIM: begin
          // scale by 0.85 above the knee, then saturating subtract
          foreach (shadow_store[i]) begin
            level = int'(shadow_store[i]);
            if (level > DIM_KNEE) level = (level * 17) / 20;
            level = (int'(val) > level) ? 0 : level - int'(val);
            shadow_store[i] = level[V_W-1:0];
          end
        end
        default: ;
      endcase
      pending_results.push_back(want);
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task check_result(input logic [V_W-1:0] rd, input logic ok);
      pixel_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("response with nothing outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (rd !== want.read_value)
        report_mismatch($sformatf("read_value %0h, want %0h", rd, want.read_value));
      if (ok !== want.position_valid)
        report_mismatch($sformatf("position_valid %0b, want %0b", ok, want.position_valid));
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lfm_cmd_if cmd_ch ();
  lfm_res_if res_ch ();

  led_matrix_framebuffer_mapper dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  framebuffer_scoreboard sb;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned holds_asked;
  int unsigned holds_granted;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold-off when one is asked for
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_granted != holds_asked) begin
        holds_granted++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor: note accepted commands, then check accepted responses
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready)
        sb.note_command(cmd_ch.operation, cmd_ch.x, cmd_ch.y, cmd_ch.value);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.read_value, res_ch.position_valid);
    end
  end

  // Offer one command, with random idle cycles ahead of it
  task automatic send_command(input logic [OP_W-1:0] op, input logic [X_W-1:0] px,
                              input logic [Y_W-1:0] py, input logic [V_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.x         <= px;
    cmd_ch.y         <= py;
    cmd_ch.value     <= val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Mostly in-bounds pixel traffic; sweeps kept rare as each one is long
  task automatic send_random_command();
    int unsigned pick;
    logic [OP_W-1:0] op;
    logic [X_W-1:0]  px;
    logic [Y_W-1:0]  py;
    logic [V_W-1:0]  val;
    pick = $urandom_range(99);
    if (pick < 45)      op = OP_WRITE;
    else if (pick < 86) op = OP_READ;
    else if (pick < 89) op = OP_FILL;
    else if (pick < 93) op = OP_DIM;
    else if (pick < 95) op = OP_CLEAR;
    else                op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    px  = X_W'(($urandom_range(99) < 88) ? $urandom_range(TOTAL_WIDTH - 1)
                                         : $urandom_range(127));
    py  = Y_W'(($urandom_range(99) < 88) ? $urandom_range(PANEL_ROWS - 1)
                                         : $urandom_range(7));
    val = V_W'($urandom_range(255));
    if (op == OP_DIM && $urandom_range(3) != 0) val = V_W'($urandom_range(20));
    send_command(op, px, py, val);
  endtask

  initial begin
    int unsigned drain;
    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    holds_asked   = 0;
    holds_granted = 0;
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= OP_WRITE;
    cmd_ch.x         <= '0;
    cmd_ch.y         <= '0;
    cmd_ch.value     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners, column fold boundaries, out of bounds, spare codes, sweeps
    send_command(OP_READ,  7'd0,   3'd0, 8'h00);
    send_command(OP_WRITE, 7'd0,   3'd0, 8'hFF);
    send_command(OP_WRITE, 7'd71,  3'd5, 8'h01);
    send_command(OP_WRITE, 7'd60,  3'd2, 8'hA5);
    send_command(OP_WRITE, 7'd59,  3'd2, 8'h5A);
    send_command(OP_WRITE, 7'd127, 3'd7, 8'h77);
    send_command(OP_WRITE, 7'd72,  3'd0, 8'h33);
    send_command(OP_READ,  7'd0,   3'd0, 8'h00);
    send_command(OP_READ,  7'd71,  3'd5, 8'h00);
    send_command(OP_READ,  7'd60,  3'd2, 8'h00);
    send_command(OP_READ,  7'd59,  3'd2, 8'h00);
    send_command(OP_READ,  7'd72,  3'd0, 8'h00);
    send_command(OP_READ,  7'd0,   3'd6, 8'h00);
    send_command(OP_SPARE_LO,  7'd0,  3'd0, 8'hFF);
    send_command(OP_SPARE_MID, 7'd10, 3'd3, 8'h11);
    send_command(OP_SPARE_HI,  7'd71, 3'd5, 8'h80);
    send_command(OP_FILL,  7'd0,   3'd0, 8'd36);
    send_command(OP_DIM,   7'd0,   3'd0, 8'd0);
    send_command(OP_READ,  7'd10,  3'd3, 8'h00);
    send_command(OP_FILL,  7'd0,   3'd0, 8'd255);
    send_command(OP_DIM,   7'd0,   3'd0, 8'd16);
    send_command(OP_READ,  7'd35,  3'd4, 8'h00);
    send_command(OP_DIM,   7'd0,   3'd0, 8'd255);
    send_command(OP_FILL,  7'd0,   3'd0, 8'd35);
    send_command(OP_DIM,   7'd0,   3'd0, 8'd1);
    send_command(OP_READ,  7'd47,  3'd1, 8'h00);
    send_command(OP_CLEAR, 7'd0,   3'd0, 8'h00);

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 63; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      // long hold-off on the result side while commands keep coming
      if (ph == 0) holds_asked++;
      for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) send_random_command();
    end
    cmd_ch.valid <= 1'b0;

    drain = 0;
    while (sb.outstanding() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.outstanding()));
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
